// ----- sv/lirs_pkg.sv -----
`default_nettype none
package lirs_pkg;

  localparam int unsigned SAMPLE_DEPTH_DEF = 1024;
  localparam int unsigned TIME_BITS_DEF    = 48;
  localparam int unsigned VALUE_BITS_DEF   = 32;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_REQUEST = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_CLEAR_X = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INTERP  = 3'd0,
    ST_EXACT   = 3'd1,
    ST_FIRST   = 3'd2,
    ST_LAST    = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_LOADED  = 3'd5,
    ST_FULL    = 3'd6,
    ST_CLEARED = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CMP,
    S_PAIR_RD,
    S_PAIR_CMP,
    S_NEXT_CMP,
    S_DIV,
    S_OUT
  } fsm_state_t;

endpackage
`default_nettype wire

// ----- sv/linear_interpolation_resampler_core.sv -----
// Linear interpolation resampler.
// Input channel (in_*): one item per handshake. in_tuser carries the mode
// (load sample, request, clear; code 3 also clears). in_tdata carries the
// time in its low bits and the sample value above it.
// Result channel (out_*): exactly one item per input item; out_tuser is the
// status, out_tdata the value (zero for load, clear and empty answers).
// One item is in flight at a time: in_tready is high only while idle.
// A load or clear goes straight from idle to the result register. A request
// walks the pointer step by step (one registered RAM read and a compare per
// step), then fetches the bracketing pair, and for an interpolation runs the
// bit-serial scaled divider before the result is registered. Requests in
// non-decreasing order walk only as far as the time advanced; a backward
// request restarts the walk from the first sample.
// Reset empties the table, zeroes the walk pointer and previous request;
// the sample RAMs are not cleared and need no sweep.
// A stalled receiver holds the result in the output register; no new item
// is taken until it is delivered.
`default_nettype none
module linear_interpolation_resampler_core
  import lirs_pkg::*;
#(
  parameter int unsigned SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  parameter int unsigned TIME_BITS    = TIME_BITS_DEF,
  parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // [TIME_BITS-1:0] item_time, [TIME_BITS+VALUE_BITS-1:TIME_BITS] sample_value, zero pad
  input  wire logic [((TIME_BITS+VALUE_BITS+7)/8)*8-1:0] in_tdata,
  // [1:0] mode
  input  wire logic [MODE_W-1:0] in_tuser,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // [VALUE_BITS-1:0] out_value, zero pad
  output logic      [((VALUE_BITS+7)/8)*8-1:0] out_tdata,
  // [2:0] status
  output logic      [STATUS_W-1:0] out_tuser
);

  localparam int unsigned OUT_DW = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned AW     = $clog2(SAMPLE_DEPTH);
  localparam int unsigned CW     = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned MAG_W  = VALUE_BITS + 1;

  fsm_state_t state_r, state_nxt;

  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         wp_r, wp_nxt;
  logic [TIME_BITS-1:0]  prev_r, prev_nxt;
  logic [TIME_BITS-1:0]  req_t_r, req_t_nxt;
  logic [TIME_BITS-1:0]  t1_r, t1_nxt;
  logic [VALUE_BITS-1:0] v1_r, v1_nxt;
  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  status_t               status_r, status_nxt;

  logic [TIME_BITS-1:0]  in_time;
  logic [VALUE_BITS-1:0] in_value;
  mode_t                 in_mode;
  logic                  in_fire;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [TIME_BITS-1:0]  t_q;
  logic [VALUE_BITS-1:0] v_q;

  logic [CW-1:0]         wp_next_ext;
  logic                  has_next;
  logic                  table_full;

  logic signed [MAG_W-1:0] dv;
  logic [MAG_W-1:0]        mag;
  logic [TIME_BITS-1:0]    div_dt;
  logic [TIME_BITS-1:0]    div_span;
  logic                    div_start;
  logic                    div_done;
  logic [MAG_W-1:0]        div_q;
  logic [MAG_W-1:0]        res;

  assign in_time   = in_tdata[TIME_BITS-1:0];
  assign in_value  = in_tdata[TIME_BITS+VALUE_BITS-1:TIME_BITS];
  assign in_mode   = mode_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign wp_next_ext = CW'(wp_r) + CW'(1);
  assign has_next    = (wp_next_ext < count_r);
  assign table_full  = (count_r >= CW'(SAMPLE_DEPTH));
  assign ram_waddr   = count_r[AW-1:0];

  lirs_ram #(.WIDTH(TIME_BITS), .DEPTH(SAMPLE_DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_time),
    .raddr (ram_raddr),
    .rdata (t_q)
  );

  lirs_ram #(.WIDTH(VALUE_BITS), .DEPTH(SAMPLE_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (v_q)
  );

  // pair differences, taken while the upper sample sits on the RAM outputs
  always_comb begin
    dv       = MAG_W'($signed(v_q)) - MAG_W'($signed(v1_r));
    mag      = dv[MAG_W-1] ? MAG_W'(-dv) : MAG_W'(dv);
    div_dt   = req_t_r - t1_r;
    div_span = t_q - t1_r;
    res      = neg_r ? (MAG_W'($signed(v1_r)) - div_q) : (MAG_W'($signed(v1_r)) + div_q);
  end

  lirs_div #(.A_W(MAG_W), .T_W(TIME_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (mag),
    .dt    (div_dt),
    .span  (div_span),
    .done  (div_done),
    .q     (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_mode == MODE_REQUEST && count_r != '0) begin
            state_nxt = S_WALK_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_WALK_RD:  state_nxt = has_next ? S_WALK_CMP : S_PAIR_RD;
      S_WALK_CMP: state_nxt = (t_q <= req_t_r) ? S_WALK_RD : S_PAIR_RD;
      S_PAIR_RD:  state_nxt = S_PAIR_CMP;
      S_PAIR_CMP: begin
        if (req_t_r <= t_q || !has_next) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_NEXT_CMP;
        end
      end
      S_NEXT_CMP: state_nxt = S_DIV;
      S_DIV:      state_nxt = div_done ? S_OUT : S_DIV;
      S_OUT:      state_nxt = out_tready ? S_IDLE : S_OUT;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    count_nxt  = count_r;
    wp_nxt     = wp_r;
    prev_nxt   = prev_r;
    req_t_nxt  = req_t_r;
    t1_nxt     = t1_r;
    v1_nxt     = v1_r;
    neg_nxt    = neg_r;
    value_nxt  = value_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_raddr  = wp_r;
    div_start  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          value_nxt = '0;
          case (in_mode)
            MODE_LOAD: begin
              if (table_full) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                count_nxt  = count_r + CW'(1);
                status_nxt = ST_LOADED;
              end
            end
            MODE_REQUEST: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                // backward request restarts the walk
                if (in_time < prev_r || CW'(wp_r) >= count_r) begin
                  wp_nxt = '0;
                end
                prev_nxt  = in_time;
                req_t_nxt = in_time;
              end
            end
            default: begin
              count_nxt  = '0;
              wp_nxt     = '0;
              prev_nxt   = '0;
              status_nxt = ST_CLEARED;
            end
          endcase
        end
      end
      S_WALK_RD: begin
        ram_raddr = wp_next_ext[AW-1:0];
      end
      S_WALK_CMP: begin
        if (t_q <= req_t_r) begin
          wp_nxt = wp_next_ext[AW-1:0];
        end
      end
      S_PAIR_RD: begin
        ram_raddr = wp_r;
      end
      S_PAIR_CMP: begin
        ram_raddr = wp_next_ext[AW-1:0];
        t1_nxt    = t_q;
        v1_nxt    = v_q;
        value_nxt = v_q;
        if (req_t_r < t_q) begin
          status_nxt = ST_FIRST;
        end else if (req_t_r == t_q) begin
          status_nxt = ST_EXACT;
        end else if (!has_next) begin
          status_nxt = ST_LAST;
        end else begin
          status_nxt = ST_INTERP;
        end
      end
      S_NEXT_CMP: begin
        neg_nxt   = dv[MAG_W-1];
        div_start = 1'b1;
      end
      S_DIV: begin
        if (div_done) begin
          value_nxt = res[VALUE_BITS-1:0];
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      wp_r    <= '0;
      prev_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wp_r    <= wp_nxt;
      prev_r  <= prev_nxt;
    end
    req_t_r  <= req_t_nxt;
    t1_r     <= t1_nxt;
    v1_r     <= v1_nxt;
    neg_r    <= neg_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = OUT_DW'(value_r);
  assign out_tuser  = status_r;

endmodule
`default_nettype wire

// ----- sv/lirs_ram.sv -----
`default_nettype none
module lirs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/lirs_div.sv -----
`default_nettype none
// floor(a * dt / span), dt < span; each bit of a, MSB first, takes a doubling phase and an add phase
module lirs_div #(
  parameter int unsigned A_W = 33,
  parameter int unsigned T_W = 48
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [A_W-1:0] a,
  input  wire logic [T_W-1:0] dt,
  input  wire logic [T_W-1:0] span,
  output logic                done,
  output logic      [A_W-1:0] q
);

  localparam int unsigned CNT_W = $clog2(A_W + 1);

  logic             run_r, run_nxt;
  logic             phase_r, phase_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [A_W-1:0]   a_r, a_nxt;
  logic [A_W-1:0]   q_r, q_nxt;
  logic [T_W-1:0]   r_r, r_nxt;
  logic [T_W-1:0]   dt_r, dt_nxt;
  logic [T_W-1:0]   span_r, span_nxt;
  logic [T_W:0]     sum;
  logic [T_W-1:0]   addend;
  logic             wrap;

  // (r + x) mod span, flagging the wrap
  always_comb begin
    addend = phase_r ? dt_r : r_r;
    sum    = {1'b0, r_r} + {1'b0, addend};
    wrap   = (sum >= {1'b0, span_r});
    if (wrap) begin
      sum = sum - {1'b0, span_r};
    end
  end

  always_comb begin
    run_nxt   = run_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    q_nxt     = q_r;
    r_nxt     = r_r;
    dt_nxt    = dt_r;
    span_nxt  = span_r;
    if (!run_r) begin
      if (start) begin
        run_nxt   = 1'b1;
        phase_nxt = 1'b0;
        cnt_nxt   = CNT_W'(A_W);
        a_nxt     = a;
        q_nxt     = '0;
        r_nxt     = '0;
        dt_nxt    = dt;
        span_nxt  = span;
      end
    end else if (!phase_r) begin
      r_nxt     = sum[T_W-1:0];
      q_nxt     = {q_r[A_W-2:0], wrap};
      phase_nxt = 1'b1;
    end else begin
      if (a_r[A_W-1]) begin
        r_nxt = sum[T_W-1:0];
        q_nxt = q_r + A_W'(wrap);
      end
      a_nxt     = {a_r[A_W-2:0], 1'b0};
      phase_nxt = 1'b0;
      cnt_nxt   = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      run_r   <= run_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    a_r    <= a_nxt;
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    dt_r   <= dt_nxt;
    span_r <= span_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

endmodule
`default_nettype wire

// ----- sv/lirs_checker.sv -----
`default_nettype none
module lirs_checker
  import lirs_pkg::*;
#(
  parameter int unsigned OUT_DW = 32
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_tvalid,
  input wire logic                in_tready,
  input wire logic [MODE_W-1:0]   in_tuser,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OUT_DW-1:0]   out_tdata,
  input wire logic [STATUS_W-1:0] out_tuser
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result item valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result item changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result item waits");

  a_clear_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[1] |=> out_tvalid && out_tuser == ST_CLEARED)
    else $error("clear not answered next cycle");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY || out_tuser == ST_LOADED ||
                   out_tuser == ST_FULL || out_tuser == ST_CLEARED) |-> out_tdata == '0)
    else $error("non-answer item carries a value");

endmodule

bind linear_interpolation_resampler_core lirs_checker #(.OUT_DW(OUT_DW)) u_lirs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ----- bench/resampler_checker.sv -----
`timescale 1ns / 1ps
module resampler_checker
  import lirs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [79:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,
  input  wire logic [2:0]  out_tuser,
  output int               fail_count,
  output int               results_owed,
  output logic [7:0]       status_seen
);

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } answer_t;

  // shadow of the sample table
  logic [47:0] time_tab [1024];
  logic [31:0] value_tab[1024];
  int unsigned tab_count;
  int unsigned walk_idx;
  logic [47:0] last_req;

  answer_t answers_due[$];
  int      errs;

  assign fail_count   = errs + answers_due.size();
  assign results_owed = answers_due.size();

  function automatic answer_t resample(mode_t m, logic [47:0] t, logic [31:0] v);
    answer_t a;
    logic signed [33:0] v1, v2, dv;
    logic [95:0] mag, dt, span, q;
    logic signed [63:0] res;
    a.value  = '0;
    a.status = ST_CLEARED;
    if (m == MODE_LOAD) begin
      if (tab_count < 1024) begin
        time_tab[tab_count]  = t;
        value_tab[tab_count] = v;
        tab_count++;
        a.status = ST_LOADED;
      end else begin
        a.status = ST_FULL;
      end
    end else if (m == MODE_REQUEST) begin
      if (tab_count == 0) begin
        a.status = ST_EMPTY;
      end else begin
        if (t < last_req || walk_idx >= tab_count) walk_idx = 0;
        last_req = t;
        while (walk_idx + 1 < tab_count && time_tab[walk_idx + 1] <= t) walk_idx++;
        if (t < time_tab[walk_idx]) begin
          a.value  = value_tab[walk_idx];
          a.status = ST_FIRST;
        end else if (t == time_tab[walk_idx]) begin
          a.value  = value_tab[walk_idx];
          a.status = ST_EXACT;
        end else if (walk_idx + 1 >= tab_count) begin
          a.value  = value_tab[walk_idx];
          a.status = ST_LAST;
        end else begin
          v1   = {{2{value_tab[walk_idx][31]}}, value_tab[walk_idx]};
          v2   = {{2{value_tab[walk_idx+1][31]}}, value_tab[walk_idx+1]};
          dv   = v2 - v1;
          mag  = dv < 0 ? 96'(-dv) : 96'(dv);
          dt   = 96'(t - time_tab[walk_idx]);
          span = 96'(time_tab[walk_idx+1] - time_tab[walk_idx]);
          q    = (mag * dt) / span;
          res  = dv < 0 ? 64'(v1) - $signed({1'b0, q[62:0]})
                        : 64'(v1) + $signed({1'b0, q[62:0]});
          a.value  = res[31:0];
          a.status = ST_INTERP;
        end
      end
    end else begin
      // both clear codes
      tab_count = 0;
      walk_idx  = 0;
      last_req  = '0;
    end
    return a;
  endfunction

  initial begin
    errs        = 0;
    tab_count   = 0;
    walk_idx    = 0;
    last_req    = '0;
    status_seen = '0;
  end

  always @(posedge clk) begin
    answer_t exp_a;
    if (rst_n && in_tvalid && in_tready)
      answers_due.push_back(resample(mode_t'(in_tuser), in_tdata[47:0], in_tdata[79:48]));
    if (rst_n && out_tvalid && out_tready) begin
      status_seen[out_tuser] <= 1'b1;
      if (answers_due.size() == 0) begin
        errs++;
        $display("%0t: unexpected result value=%h status=%0d", $time, out_tdata, out_tuser);
      end else begin
        exp_a = answers_due.pop_front();
        if (out_tdata !== exp_a.value) begin
          errs++;
          $display("%0t: value expected %h actual %h", $time, exp_a.value, out_tdata);
        end
        if (out_tuser !== exp_a.status) begin
          errs++;
          $display("%0t: status expected %0d actual %0d", $time, exp_a.status, out_tuser);
        end
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import lirs_pkg::*;

  localparam logic [47:0] T_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam int          N_ITEMS   = 1350;
  // worst quiet spell: backward walk over a full table plus divide plus stalls
  localparam int          DOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [47:0] item_time, [79:48] sample_value
  logic [79:0] in_tdata = '0;
  // [1:0] mode
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [31:0] out_value
  logic [31:0] out_tdata;
  // [2:0] status
  logic [2:0]  out_tuser;

  int          fails, owed;
  logic [7:0]  seen;
  int          items_sent = 0;
  bit          tx_idle = 1'b1;   // sender gaps on/off for this stretch
  bit          rx_idle = 1'b1;   // receiver stalls on/off
  bit          hold_rx = 1'b0;   // request for one long receiver hold-off
  int          quiet = 0;

  logic [47:0] tab_times[$];     // times loaded in the current phase

  initial forever #2 clk = ~clk;

  linear_interpolation_resampler_core dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  resampler_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .fail_count(fails), .results_owed(owed), .status_seen(seen)
  );

  // watchdog: any handshake resets the quiet count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= DOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, owed);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) rx_idle = ~rx_idle;
      stall = rx_idle ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic logic [47:0] rand_time();
    return {$urandom(), $urandom()} & T_MAX;
  endfunction

  // one item through the input channel; valid stays high across back-to-back items
  task automatic send_item(mode_t m, logic [47:0] t, logic [31:0] v);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {v, t};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // one edge first so the item just accepted is counted as owed
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  // table phase: clear, a run of loads (sorted unless shuffled), then mostly forward requests
  task automatic table_phase(int n_loads, int n_reqs);
    logic [63:0] cur, step_max, rq;
    logic [47:0] t;
    bit          shuffled;
    int          k;
    shuffled = ($urandom_range(0, 7) == 0);
    step_max = 64'd1 << $urandom_range(0, 40);
    tab_times.delete();
    send_item($urandom_range(0, 1) ? MODE_CLEAR : MODE_CLEAR_X, rand_time(), $urandom());
    cur = $urandom_range(0, 3) == 0 ? 64'd0 : 64'(rand_time() >> $urandom_range(1, 24));
    for (int i = 0; i < n_loads; i++) begin
      cur = cur + 64'd1 + ({$urandom(), $urandom()} % step_max);
      t   = shuffled ? rand_time() : cur[47:0];
      tab_times.push_back(t);
      send_item(MODE_LOAD, t, $urandom());
    end
    rq = tab_times[0] > 0 ? 64'(tab_times[0]) - 64'd1 : 64'd0;
    for (int i = 0; i < n_reqs; i++) begin
      case ($urandom_range(0, 11))
        0:       rq = 64'(rand_time());                 // may step backwards
        1, 2: begin
          k  = $urandom_range(0, tab_times.size() - 1); // exact hit
          rq = 64'(tab_times[k]);
        end
        3:       rq = 64'(T_MAX);
        default: rq = rq + ({$urandom(), $urandom()} % (step_max * 2));
      endcase
      if (rq > 64'(T_MAX)) rq = 64'(T_MAX);
      send_item(MODE_REQUEST, rq[47:0], $urandom());
      if ($urandom_range(0, 19) == 0)                   // stray item
        send_item(mode_t'($urandom_range(0, 3)), rand_time(), $urandom());
    end
  endtask

  initial begin
    logic [47:0] t;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges of the fields and each corner case
    send_item(MODE_REQUEST, 48'd5, 32'd0);              // empty table
    send_item(MODE_LOAD, 48'd0, 32'h8000_0000);
    send_item(MODE_LOAD, 48'd100, 32'h7FFF_FFFF);
    send_item(MODE_LOAD, T_MAX, 32'h0000_0000);
    send_item(MODE_REQUEST, 48'd0, 32'hFFFF_FFFF);      // exact first
    send_item(MODE_REQUEST, 48'd50, 32'd0);             // full-scale rise
    send_item(MODE_REQUEST, 48'd100, 32'd0);            // exact middle
    send_item(MODE_REQUEST, 48'd101, 32'd0);            // fall from max to zero, huge span
    send_item(MODE_REQUEST, 48'hFFFF_FFFF_FFFE, 32'd0);
    send_item(MODE_REQUEST, T_MAX, 32'd0);              // exact on last sample
    send_item(MODE_REQUEST, 48'd10, 32'd0);             // backward restart
    send_item(MODE_CLEAR, 48'd0, 32'd0);
    send_item(MODE_LOAD, 48'd1000, 32'd5);
    send_item(MODE_REQUEST, 48'd999, 32'd0);            // before first
    send_item(MODE_REQUEST, 48'd2000, 32'd0);           // after only sample
    send_item(MODE_CLEAR_X, T_MAX, 32'hFFFF_FFFF);      // code 3 clears too
    send_item(MODE_REQUEST, 48'd5, 32'd0);
    send_item(MODE_LOAD, 48'd7, 32'hFFFF_0000);
    send_item(MODE_LOAD, 48'd7, 32'h0001_0000);         // duplicate time
    send_item(MODE_LOAD, 48'd3, 32'h1234_5678);         // out of order
    send_item(MODE_REQUEST, 48'd7, 32'd0);
    send_item(MODE_REQUEST, 48'd8, 32'd0);
    drain();

    // fill the table to the brim, then overflow it
    send_item(MODE_CLEAR, 48'd0, 32'd0);
    t = 48'd0;
    for (int i = 0; i < 1027; i++) begin
      t = t + 48'($urandom_range(1, 1000));
      send_item(MODE_LOAD, t, $urandom());
    end
    send_item(MODE_REQUEST, t, 32'd0);
    send_item(MODE_REQUEST, 48'd1, 32'd0);              // backward restart
    send_item(MODE_REQUEST, t >> 1, 32'd0);
    hold_rx = 1'b1;                                     // long receiver hold-off
    for (int i = 0; i < 6; i++) send_item(MODE_REQUEST, rand_time(), 32'd0);
    drain();

    // random phases until the item budget is used
    while (items_sent < N_ITEMS) begin
      tx_idle = $urandom_range(0, 3) != 0;
      table_phase($urandom_range(2, 24), $urandom_range(4, 30));
      if ($urandom_range(0, 2) == 0) drain();
    end

    drain();
    repeat (2200) @(posedge clk);
    $display("run: %0d items sent, table filled past capacity once", items_sent);
    $display("run: status codes observed (bit per code) %b", seen);
    if (fails == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- linear_interpolation_resampler_core.f -----
sv/lirs_pkg.sv
sv/lirs_ram.sv
sv/lirs_div.sv
sv/linear_interpolation_resampler_core.sv
sv/lirs_checker.sv
bench/resampler_checker.sv
bench/testbench.sv
